// ===== rtl/core/yuvrgb_pkg.sv =====
// Shared types, register indexes, font ROM and chroma term functions for the YUV to RGB565 unit.
package yuvrgb_pkg;

    // Configuration port geometry
    localparam int CFG_DATA_W = 60;
    localparam int CFG_IDX_W  = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STAMP_CHARS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR   = 3'd4;

    // Register reset values
    localparam logic [12:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [59:0] STAMP_CHARS_RST  = 60'hFFF_FFFF_FFFF_FFFF;
    localparam logic [15:0] TEXT_COLOR_RST   = 16'hFFFF;
    localparam logic [15:0] BACK_COLOR_RST   = 16'h0000;

    // Stamp box geometry
    localparam int BOX_W      = 120;
    localparam int BOX_H      = 16;
    localparam int BOX_UP     = 20;
    localparam int GLYPH_TOP  = 4;
    localparam int GLYPH_ROWS = 8;
    localparam int SLOTS      = 15;
    localparam logic [3:0] CODE_BLANK = 4'hF;

    // Pixel source picked by the stamp logic
    typedef enum logic [1:0] {
        SRC_CONV,
        SRC_BACK,
        SRC_TEXT
    } pix_src_t;

    // Stamp-related configuration handed to the stamp pipeline
    typedef struct packed {
        logic [12:0] frame_width;
        logic [12:0] frame_height;
        logic [59:0] stamp_chars;
    } stamp_cfg_t;

    // Per-stage load enables
    typedef struct packed {
        logic a;
        logic b;
    } stage_en_t;

    // 8x8 font, MSB is the leftmost column; codes 12-15 are blank
    localparam logic [7:0] GLYPH_ROM [16][8] = '{
        '{8'h3C, 8'h66, 8'h6E, 8'h76, 8'h66, 8'h66, 8'h3C, 8'h00},
        '{8'h10, 8'h30, 8'h50, 8'h10, 8'h10, 8'h10, 8'h7C, 8'h00},
        '{8'h3E, 8'h60, 8'h60, 8'h3E, 8'h06, 8'h06, 8'h7E, 8'h00},
        '{8'h3E, 8'h60, 8'h60, 8'h3E, 8'h60, 8'h60, 8'h3E, 8'h00},
        '{8'h66, 8'h66, 8'h66, 8'h7E, 8'h06, 8'h06, 8'h06, 8'h00},
        '{8'h7E, 8'h06, 8'h06, 8'h7E, 8'h60, 8'h60, 8'h3E, 8'h00},
        '{8'h3E, 8'h06, 8'h06, 8'h7E, 8'h66, 8'h66, 8'h3E, 8'h00},
        '{8'h7E, 8'h60, 8'h60, 8'h60, 8'h60, 8'h60, 8'h60, 8'h00},
        '{8'h3E, 8'h66, 8'h66, 8'h3E, 8'h66, 8'h66, 8'h3E, 8'h00},
        '{8'h3E, 8'h66, 8'h66, 8'h3E, 8'h60, 8'h60, 8'h3E, 8'h00},
        '{8'h00, 8'h18, 8'h18, 8'h00, 8'h00, 8'h18, 8'h18, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h7E, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    // Fixed-point multipliers for 1.13983 and 1.5748, rounded up; exact floor for |d| <= 128
    localparam logic [24:0] CB_RECIP = 25'd19123175;
    localparam int          CB_SHIFT = 24;
    localparam logic [20:0] CR_RECIP = 21'd1651298;
    localparam int          CR_SHIFT = 20;

    // trunc((c-128)*1.13983), rounded toward zero
    function automatic logic signed [8:0] cb_term(input logic [7:0] c);
        logic signed [8:0] d;
        logic [7:0]        mag;
        logic [32:0]       prod;
        logic [7:0]        q;
        d    = $signed({1'b0, c}) - 9'sd128;
        mag  = d[8] ? 8'(-d) : 8'(d);
        prod = 33'(mag) * 33'(CB_RECIP);
        q    = 8'(prod >> CB_SHIFT);
        return d[8] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    // trunc((c-128)*1.5748), rounded toward zero
    function automatic logic signed [8:0] cr_term(input logic [7:0] c);
        logic signed [8:0] d;
        logic [7:0]        mag;
        logic [28:0]       prod;
        logic [7:0]        q;
        d    = $signed({1'b0, c}) - 9'sd128;
        mag  = d[8] ? 8'(-d) : 8'(d);
        prod = 29'(mag) * 29'(CR_RECIP);
        q    = 8'(prod >> CR_SHIFT);
        return d[8] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

endpackage

// ===== rtl/core/yuvrgb_if.sv =====
// Valid/ready channel interfaces for pixels in and RGB565 pixels out.
interface yuvrgb_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  luma;
    logic [7:0]  chroma_blue;
    logic [7:0]  chroma_red;
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;

    modport source (
        output valid, luma, chroma_blue, chroma_red, pixel_col, pixel_row,
        input  ready
    );
    modport sink (
        input  valid, luma, chroma_blue, chroma_red, pixel_col, pixel_row,
        output ready
    );
endinterface

interface yuvrgb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_rgb;

    modport source (
        output valid, pixel_rgb,
        input  ready
    );
    modport sink (
        input  valid, pixel_rgb,
        output ready
    );
endinterface

// ===== rtl/core/yuv_to_rgb565_with_stamp_unit.sv =====
// Top level: YUV 4:2:0 pixel to RGB565 converter with timestamp overlay box.
//
// Usage:
//   pix_in carries one pixel per item: luma, the chroma pair of its 2x2 group,
//   and its column and row. pix_out carries the RGB565 result, one per item,
//   in input order. cfg_write/cfg_index/cfg_data write frame size, stamp glyph
//   codes and the two stamp colors; write them only while no item is in flight.
// Pipeline: three register stages (stage A, stage B, output register); an item
//   accepted into stage A moves through stage B into the output register, where
//   it shows on pix_out.valid.
// Throughput: one item per cycle while the receiver takes every item; each stage
//   is a fixed constant-multiply, add or compare step, so nothing iterates.
// Reset: rst_n clears all stage valid bits and loads the register defaults
//   (640x480 frame, all slots blank, white text on black box).
// Stall: when pix_out.ready is low the output register holds its item; each
//   earlier stage still advances into an empty slot, so pix_in.ready stays
//   high until every stage holds an item.
module yuv_to_rgb565_with_stamp_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [yuvrgb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [yuvrgb_pkg::CFG_DATA_W-1:0] cfg_data,
    yuvrgb_in_if.sink                         pix_in,
    yuvrgb_out_if.source                      pix_out
);
    import yuvrgb_pkg::*;

    logic [12:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic [59:0] stamp_chars_reg;
    logic [15:0] text_color_reg;
    logic [15:0] back_color_reg;

    logic a_valid_reg;
    logic b_valid_reg;
    logic out_valid_reg;
    logic ready_a;
    logic ready_b;
    logic ready_out;

    stage_en_t  en;
    stamp_cfg_t stamp_cfg;
    logic [15:0] conv_rgb;
    pix_src_t    pix_src;
    logic [15:0] pixel_next;
    logic [15:0] pixel_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            stamp_chars_reg  <= STAMP_CHARS_RST;
            text_color_reg   <= TEXT_COLOR_RST;
            back_color_reg   <= BACK_COLOR_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[12:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[12:0];
                REG_STAMP_CHARS:  stamp_chars_reg  <= cfg_data[59:0];
                REG_TEXT_COLOR:   text_color_reg   <= cfg_data[15:0];
                REG_BACK_COLOR:   back_color_reg   <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    // Advance a stage when its successor is empty or moving
    always_comb
    begin
        ready_out = !out_valid_reg || pix_out.ready;
        ready_b   = !b_valid_reg || ready_out;
        ready_a   = !a_valid_reg || ready_b;
        en.a      = ready_a;
        en.b      = ready_b;
    end

    assign pix_in.ready = ready_a;

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
                a_valid_reg <= pix_in.valid;
            if (ready_b)
                b_valid_reg <= a_valid_reg;
            if (ready_out)
                out_valid_reg <= b_valid_reg;
        end
    end

    assign stamp_cfg = '{
        frame_width:  frame_width_reg,
        frame_height: frame_height_reg,
        stamp_chars:  stamp_chars_reg
    };

    yuvrgb_color u_color (
        .clk         (clk),
        .en          (en),
        .luma        (pix_in.luma),
        .chroma_blue (pix_in.chroma_blue),
        .chroma_red  (pix_in.chroma_red),
        .pixel_rgb   (conv_rgb)
    );

    yuvrgb_stamp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_stamp (
        .clk       (clk),
        .en        (en),
        .cfg       (stamp_cfg),
        .pixel_col (pix_in.pixel_col),
        .pixel_row (pix_in.pixel_row),
        .pix_src   (pix_src)
    );

    // Output stage: pick converted pixel or stamp color
    always_comb
    begin
        unique case (pix_src)
            SRC_CONV: pixel_next = conv_rgb;
            SRC_BACK: pixel_next = back_color_reg;
            SRC_TEXT: pixel_next = text_color_reg;
            default:  pixel_next = conv_rgb;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ready_out)
            pixel_reg <= pixel_next;
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.pixel_rgb = pixel_reg;

endmodule

// ===== rtl/core/yuvrgb_color.sv =====
// Two-stage YUV to RGB565 color conversion datapath.
module yuvrgb_color (
    input  logic                  clk,
    input  yuvrgb_pkg::stage_en_t en,
    input  logic [7:0]            luma,
    input  logic [7:0]            chroma_blue,
    input  logic [7:0]            chroma_red,
    output logic [15:0]           pixel_rgb
);
    import yuvrgb_pkg::*;

    // Clamp a signed sum to 0..255
    function automatic logic [7:0] clamp8(input logic signed [9:0] v);
        logic [7:0] res;
        if (v[9])
            res = 8'd0;
        else if (v > 10'sd255)
            res = 8'd255;
        else
            res = v[7:0];
        return res;
    endfunction

    logic signed [8:0] yp_reg;
    logic signed [8:0] cbt_reg;
    logic signed [8:0] crt_reg;

    logic signed [16:0] mix;
    logic signed [8:0]  shifted_next;
    logic signed [9:0]  r_sum_next;
    logic signed [9:0]  b_sum_next;

    logic signed [8:0] yp_b_reg;
    logic signed [8:0] shifted_reg;
    logic signed [9:0] r_sum_reg;
    logic signed [9:0] b_sum_reg;

    logic signed [9:0] g_sum;
    logic [7:0]        r8;
    logic [7:0]        g8;
    logic [7:0]        b8;

    // Stage A: offset luma, look up chroma terms
    always_ff @(posedge clk)
    begin
        if (en.a)
        begin
            yp_reg  <= $signed({1'b0, luma}) - 9'sd16;
            cbt_reg <= cb_term(chroma_blue);
            crt_reg <= cr_term(chroma_red);
        end
    end

    // Stage B: green mix with floor shift, red and blue sums
    always_comb
    begin
        mix = {{8{cbt_reg[8]}}, cbt_reg} * 17'sd54 + {{8{crt_reg[8]}}, crt_reg} * 17'sd183;
        shifted_next = 9'(mix >>> 8);
        r_sum_next   = {yp_reg[8], yp_reg} + {crt_reg[8], crt_reg};
        b_sum_next   = {yp_reg[8], yp_reg} + {cbt_reg[8], cbt_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en.b)
        begin
            yp_b_reg    <= yp_reg;
            shifted_reg <= shifted_next;
            r_sum_reg   <= r_sum_next;
            b_sum_reg   <= b_sum_next;
        end
    end

    // Finish green, clamp and pack
    always_comb
    begin
        g_sum     = {yp_b_reg[8], yp_b_reg} - {shifted_reg[8], shifted_reg};
        r8        = clamp8(r_sum_reg);
        g8        = clamp8(g_sum);
        b8        = clamp8(b_sum_reg);
        pixel_rgb = {r8[7:3], g8[7:2], b8[7:3]};
    end

endmodule

// ===== rtl/core/yuvrgb_stamp.sv =====
// Two-stage stamp box placement and glyph lookup; picks the pixel source.
module yuvrgb_stamp #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                   clk,
    input  yuvrgb_pkg::stage_en_t  en,
    input  yuvrgb_pkg::stamp_cfg_t cfg,
    input  logic [11:0]            pixel_col,
    input  logic [11:0]            pixel_row,
    output yuvrgb_pkg::pix_src_t   pix_src
);
    import yuvrgb_pkg::*;

    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int BX_W  = ((WID_W > 12) ? WID_W : 12) + 2;
    localparam int BY_W  = ((HGT_W > 12) ? HGT_W : 12) + 2;

    logic [WID_W-1:0] w_lim;
    logic [HGT_W-1:0] h_lim;
    logic             in_frame;
    logic [BX_W-1:0]  bx;
    logic [BY_W-1:0]  by;
    logic             in_box_next;

    logic       in_box_reg;
    logic [3:0] slot_reg;
    logic [2:0] dx_reg;
    logic [3:0] by_reg;

    logic [3:0] codes [16];
    logic [3:0] code;
    logic [2:0] dy;
    logic [7:0] glyph_row;
    logic       in_rows;
    pix_src_t   src_next;
    pix_src_t   src_reg;

    // Stage A: clip frame size, locate pixel against the box
    always_comb
    begin
        w_lim  = (int'(cfg.frame_width) > MAX_WIDTH) ? WID_W'(MAX_WIDTH)
                                                     : WID_W'(cfg.frame_width);
        h_lim  = (int'(cfg.frame_height) > MAX_HEIGHT) ? HGT_W'(MAX_HEIGHT)
                                                       : HGT_W'(cfg.frame_height);
        in_frame = (BX_W'(pixel_col) < BX_W'(w_lim)) && (BY_W'(pixel_row) < BY_W'(h_lim));
        bx     = BX_W'(pixel_col) - BX_W'(w_lim) + BX_W'(BOX_W);
        by     = BY_W'(pixel_row) - BY_W'(h_lim) + BY_W'(BOX_UP);
        in_box_next = in_frame
                   && !bx[BX_W-1] && (bx < BX_W'(BOX_W))
                   && !by[BY_W-1] && (by < BY_W'(BOX_H));
    end

    always_ff @(posedge clk)
    begin
        if (en.a)
        begin
            in_box_reg <= in_box_next;
            slot_reg   <= bx[6:3];
            dx_reg     <= bx[2:0];
            by_reg     <= by[3:0];
        end
    end

    // Stage B: glyph code of the slot, font row, pick source
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
            codes[i] = cfg.stamp_chars[4*i +: 4];
        codes[15] = CODE_BLANK;
        code      = codes[slot_reg];
        dy        = 3'(by_reg - 4'(GLYPH_TOP));
        glyph_row = GLYPH_ROM[code][dy];
        in_rows   = (by_reg >= 4'(GLYPH_TOP)) && (by_reg < 4'(GLYPH_TOP + GLYPH_ROWS));
        priority if (!in_box_reg)
            src_next = SRC_CONV;
        else if (in_rows && glyph_row[~dx_reg])
            src_next = SRC_TEXT;
        else
            src_next = SRC_BACK;
    end

    always_ff @(posedge clk)
    begin
        if (en.b)
            src_reg <= src_next;
    end

    assign pix_src = src_reg;

endmodule

// ===== rtl/core/yuvrgb_checker.sv =====
// Port-level checker for the YUV to RGB565 unit and its bind.
module yuvrgb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] pixel_rgb
);

    // Hold a stalled output item
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_rgb))
        else $error("stalled output item changed or dropped");

    // Deliver an accepted item through both stages to the output when the receiver keeps taking
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("accepted item did not reach the output in three cycles");

    // Take input whenever the output register is empty
    a_skid: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output register is empty");

    // Drop every item in flight on reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid right after reset");

endmodule

bind yuv_to_rgb565_with_stamp_unit yuvrgb_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .pixel_rgb (pix_out.pixel_rgb)
);

// ===== verif/yuv_to_rgb565_with_stamp_unit_tb.sv =====
// Testbench for the YUV to RGB565 unit: directed and random pixels checked against a local predictor.
`timescale 1ns / 1ps

module yuv_to_rgb565_with_stamp_unit_tb;
    import yuvrgb_pkg::*;

    localparam int FRAME_MAX_W   = 4096;
    localparam int FRAME_MAX_H   = 4096;
    localparam int STAMP_W       = 120;
    localparam int STAMP_H       = 16;
    localparam int STAMP_RISE    = 20;
    localparam int TEXT_TOP      = 4;
    localparam int SLOT_COUNT    = 15;
    localparam logic [3:0] CODE_COLON = 4'd10;
    localparam logic [3:0] CODE_DASH  = 4'd11;
    localparam logic [3:0] CODE_BLANK_FIRST = 4'd12;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_CHUNKS = 9;
    localparam int CHUNK_ITEMS   = 95;
    localparam int WATCHDOG_NS   = 5_000_000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    yuvrgb_in_if  in_ch ();
    yuvrgb_out_if out_ch ();

    yuv_to_rgb565_with_stamp_unit #(
        .MAX_WIDTH  (FRAME_MAX_W),
        .MAX_HEIGHT (FRAME_MAX_H)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (in_ch),
        .pix_out   (out_ch)
    );

    // Shadow copy of the unit's registers
    logic [12:0] cur_width;
    logic [12:0] cur_height;
    logic [59:0] cur_chars;
    logic [15:0] cur_text;
    logic [15:0] cur_back;

    logic [15:0] expected_rgb_q [$];
    int          error_count = 0;
    int          src_idle_pct;
    int          sink_idle_pct;

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // End the run if it hangs
    initial
    begin
        #(WATCHDOG_NS);
        $display("DONE: errors detected");
        $finish;
    end

    // Font rows, top row in the high byte, leftmost pixel in the msb; digit codes equal the digit
    function automatic logic [63:0] glyph_rows(input logic [3:0] code);
        case (code)
            4'd0:       return 64'h3C66_6E76_6666_3C00;
            4'd1:       return 64'h1030_5010_1010_7C00;
            4'd2:       return 64'h3E60_603E_0606_7E00;
            4'd3:       return 64'h3E60_603E_6060_3E00;
            4'd4:       return 64'h6666_667E_0606_0600;
            4'd5:       return 64'h7E06_067E_6060_3E00;
            4'd6:       return 64'h3E06_067E_6666_3E00;
            4'd7:       return 64'h7E60_6060_6060_6000;
            4'd8:       return 64'h3E66_663E_6666_3E00;
            4'd9:       return 64'h3E66_663E_6060_3E00;
            CODE_COLON: return 64'h0018_1800_0018_1800;
            CODE_DASH:  return 64'h0000_007E_0000_0000;
            default:    return 64'h0;
        endcase
    endfunction

    function automatic logic [7:0] chan_clamp(input int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return 8'(v);
    endfunction

    // Work out the RGB565 value of one pixel under the current register settings
    function automatic logic [15:0] predict_rgb(input logic [7:0] y, input logic [7:0] cb,
                                                input logic [7:0] cr, input logic [11:0] col,
                                                input logic [11:0] row);
        int          y_off;
        int          cb_t;
        int          cr_t;
        int          mix;
        int          w_eff;
        int          h_eff;
        int          bx;
        int          by;
        int          dy;
        int          slot;
        logic [7:0]  r8;
        logic [7:0]  g8;
        logic [7:0]  b8;
        logic [3:0]  code;
        logic [63:0] rows;
        logic [15:0] pix;
        y_off = int'(y) - 16;
        cb_t  = (int'(cb) - 128) * 113983 / 100000;
        cr_t  = (int'(cr) - 128) * 15748 / 10000;
        mix   = cb_t * 54 + cr_t * 183;
        r8    = chan_clamp(y_off + cr_t);
        g8    = chan_clamp(y_off - (mix >>> 8));
        b8    = chan_clamp(y_off + cb_t);
        pix   = {r8[7:3], g8[7:2], b8[7:3]};
        w_eff = (cur_width > FRAME_MAX_W) ? FRAME_MAX_W : int'(cur_width);
        h_eff = (cur_height > FRAME_MAX_H) ? FRAME_MAX_H : int'(cur_height);
        if (int'(col) < w_eff && int'(row) < h_eff)
        begin
            bx = int'(col) - (w_eff - STAMP_W);
            by = int'(row) - (h_eff - STAMP_RISE);
            if (bx >= 0 && bx < STAMP_W && by >= 0 && by < STAMP_H)
            begin
                pix  = cur_back;
                slot = bx >> 3;
                dy   = by - TEXT_TOP;
                if (slot < SLOT_COUNT && dy >= 0 && dy < 8)
                begin
                    code = cur_chars[4 * slot +: 4];
                    rows = glyph_rows(code);
                    if (code < CODE_BLANK_FIRST && rows[63 - 8 * dy - (bx & 7)])
                        pix = cur_text;
                end
            end
        end
        return pix;
    endfunction

    // Pick a coordinate: mostly near the far edge where the stamp sits, some in frame, some anywhere
    function automatic logic [11:0] pick_coord(input int extent, input int depth);
        int c;
        int pick;
        pick = int'($urandom_range(99));
        if (extent > 0 && pick < 65)
            c = extent - 1 - int'($urandom_range(depth));
        else if (extent > 0 && pick < 85)
            c = int'($urandom_range(extent - 1));
        else
            c = int'($urandom_range(4095));
        if (c < 0)
            c = int'($urandom_range(extent - 1));
        return 12'(c);
    endfunction

    // Offer one item, idling at random first; valid stays high for a following item
    task automatic send_pixel(input logic [7:0] y, input logic [7:0] cb, input logic [7:0] cr,
                              input logic [11:0] col, input logic [11:0] row);
        while (int'($urandom_range(99)) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.luma        <= y;
        in_ch.chroma_blue <= cb;
        in_ch.chroma_red  <= cr;
        in_ch.pixel_col   <= col;
        in_ch.pixel_row   <= row;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_rgb_q.push_back(predict_rgb(y, cb, cr, col, row));
    endtask

    // Drop valid and wait until every expected result is out
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_rgb_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register and mirror it in the shadow copy
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_FRAME_WIDTH:  cur_width  = data[12:0];
            REG_FRAME_HEIGHT: cur_height = data[12:0];
            REG_STAMP_CHARS:  cur_chars  = data[59:0];
            REG_TEXT_COLOR:   cur_text   = data[15:0];
            REG_BACK_COLOR:   cur_back   = data[15:0];
            default: ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(input int w, input int h);
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    endtask

    // Register defaults after reset: blank slots on a black box at 640x480
    task automatic test_reset_defaults();
        send_pixel(8'd128, 8'd128, 8'd128, 12'd0, 12'd0);
        send_pixel(8'd200, 8'd90, 8'd170, 12'd520, 12'd460);
        send_pixel(8'd50, 8'd30, 8'd220, 12'd639, 12'd475);
        send_pixel(8'd99, 8'd140, 8'd60, 12'd519, 12'd460);
        send_pixel(8'd180, 8'd10, 8'd250, 12'd640, 12'd470);
    endtask

    // Extremes of luma and chroma, including the low-luma clamp
    task automatic test_color_extremes();
        send_pixel(8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
        send_pixel(8'd15, 8'd255, 8'd255, 12'd1, 12'd0);
        send_pixel(8'd16, 8'd128, 8'd128, 12'd2, 12'd0);
        send_pixel(8'd255, 8'd255, 8'd0, 12'd3, 12'd0);
        send_pixel(8'd255, 8'd0, 8'd255, 12'd4, 12'd0);
        send_pixel(8'd235, 8'd240, 8'd16, 12'd4095, 12'd4095);
    endtask

    // Glyph codes 0 to 14 loaded across the slots; spare register indexes must be ignored
    task automatic test_glyph_slots();
        wait_idle();
        // slot i holds code i
        write_reg(REG_STAMP_CHARS, 60'hEDC_BA98_7654_3210);
        write_reg(REG_TEXT_COLOR, 60'hF800);
        write_reg(REG_BACK_COLOR, 60'h001F);
        for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'({$urandom, $urandom}));
        send_pixel(8'd40, 8'd40, 8'd40, 12'd522, 12'd464);
        send_pixel(8'd40, 8'd40, 8'd40, 12'd522, 12'd471);
        send_pixel(8'd70, 8'd200, 8'd20, 12'd603, 12'd465);
        send_pixel(8'd70, 8'd200, 8'd20, 12'd609, 12'd467);
        send_pixel(8'd70, 8'd200, 8'd20, 12'd618, 12'd467);
        send_pixel(8'd120, 8'd77, 8'd180, 12'd560, 12'd460);
        send_pixel(8'd120, 8'd77, 8'd180, 12'd560, 12'd475);
    endtask

    // Oversized, zero and tiny frames
    task automatic test_frame_limits();
        wait_idle();
        set_frame(8191, 8191);
        send_pixel(8'd60, 8'd100, 8'd160, 12'd3976, 12'd4076);
        send_pixel(8'd60, 8'd100, 8'd160, 12'd4095, 12'd4083);
        wait_idle();
        set_frame(0, 0);
        send_pixel(8'd90, 8'd110, 8'd130, 12'd0, 12'd0);
        wait_idle();
        set_frame(50, 10);
        send_pixel(8'd90, 8'd110, 8'd130, 12'd0, 12'd0);
        send_pixel(8'd90, 8'd110, 8'd130, 12'd49, 12'd9);
        send_pixel(8'd90, 8'd110, 8'd130, 12'd60, 12'd5);
        wait_idle();
        set_frame(1, 1);
        send_pixel(8'd90, 8'd110, 8'd130, 12'd0, 12'd0);
    endtask

    // Random pixels in chunks, each under fresh register settings; the idle pattern changes every third chunk
    task automatic test_random_traffic();
        int w;
        int h;
        int w_eff;
        int h_eff;
        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++)
        begin
            wait_idle();
            case (chunk / 3)
                0:       begin src_idle_pct = 26; sink_idle_pct = 71; end
                1:       begin src_idle_pct = 71; sink_idle_pct = 26; end
                default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
            endcase
            case (chunk)
                0:       begin w = FRAME_MAX_W; h = FRAME_MAX_H; end
                1:       begin w = int'($urandom_range(8191, 4097));
                               h = int'($urandom_range(8191, 4097)); end
                2:       begin w = 1; h = 1; end
                3:       begin w = 0; h = int'($urandom_range(4096)); end
                4:       begin w = int'($urandom_range(119, 1));
                               h = int'($urandom_range(19, 1)); end
                default: begin w = int'($urandom_range(4096, 120));
                               h = int'($urandom_range(4096, 20)); end
            endcase
            set_frame(w, h);
            write_reg(REG_STAMP_CHARS, CFG_DATA_W'({$urandom, $urandom}));
            write_reg(REG_TEXT_COLOR, CFG_DATA_W'($urandom_range(16'hFFFF)));
            write_reg(REG_BACK_COLOR, CFG_DATA_W'($urandom_range(16'hFFFF)));
            w_eff = (cur_width > FRAME_MAX_W) ? FRAME_MAX_W : int'(cur_width);
            h_eff = (cur_height > FRAME_MAX_H) ? FRAME_MAX_H : int'(cur_height);
            for (int n = 0; n < CHUNK_ITEMS; n++)
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                           pick_coord(w_eff, STAMP_W - 1), pick_coord(h_eff, STAMP_RISE - 1));
        end
    endtask

    // Take results and compare each with the oldest expectation
    always @(posedge clk)
    begin : result_check
        logic [15:0] want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_rgb_q.size() == 0)
            begin
                $error("pixel_rgb: unexpected item, got %h", out_ch.pixel_rgb);
                error_count++;
            end
            else
            begin
                want = expected_rgb_q.pop_front();
                if (out_ch.pixel_rgb !== want)
                begin
                    $error("pixel_rgb mismatch: expected %h, got %h", want, out_ch.pixel_rgb);
                    error_count++;
                end
            end
        end
        out_ch.ready <= (int'($urandom_range(99)) >= sink_idle_pct);
    end

    // Reset, run each test in turn, then report
    initial
    begin
        src_idle_pct      = 26;
        sink_idle_pct     = 71;
        cur_width         = FRAME_WIDTH_RST;
        cur_height        = FRAME_HEIGHT_RST;
        cur_chars         = STAMP_CHARS_RST;
        cur_text          = TEXT_COLOR_RST;
        cur_back          = BACK_COLOR_RST;
        rst_n             <= 1'b0;
        cfg_write         <= 1'b0;
        cfg_index         <= REG_FRAME_WIDTH;
        cfg_data          <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.luma        <= '0;
        in_ch.chroma_blue <= '0;
        in_ch.chroma_red  <= '0;
        in_ch.pixel_col   <= '0;
        in_ch.pixel_row   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_color_extremes();
        test_glyph_slots();
        test_frame_limits();
        test_random_traffic();
        wait_idle();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
